// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file pjb_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous reset
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// next-cycle implication under synchronous reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

// ===== hw/rtl/pjb_pkg.sv =====
// pcm jitter buffer package: sizes, request codes, payload and internal structs
// no dependencies
`timescale 1ns / 1ps

package pjb_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int SAMPLE_BITS = 16;
   localparam int IDX_BITS    = $clog2(STORE_DEPTH);
   localparam int FILL_BITS   = $clog2(STORE_DEPTH + 1);
   localparam int TOTAL_BITS  = 32;
   localparam int CSR_BITS    = 11;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CAPACITY = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_PREFILL  = CSR_IDX_BITS'(1);

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_PULL  = 2'd1,
      REQ_CLEAR = 2'd2
   } pjb_op_type;

   typedef struct packed {
      logic [1:0]                    req_type;
      logic signed [SAMPLE_BITS-1:0] in_sample;
      logic                          end_of_call;
   } pjb_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_sample;
      logic                          sample_real;
      logic                          dropped_now;
      logic [FILL_BITS-1:0]          fill_level;
      logic                          priming_now;
      logic [TOTAL_BITS-1:0]         underrun_total;
      logic [TOTAL_BITS-1:0]         dropped_total;
      logic                          end_marker;
   } pjb_rsp_type;

   typedef struct packed {
      logic                   wr_en;
      logic [IDX_BITS-1:0]    wr_addr;
      logic [SAMPLE_BITS-1:0] wr_data;
      logic                   rd_en;
      logic [IDX_BITS-1:0]    rd_addr;
   } pjb_mem_type;

   typedef struct packed {
      logic                  sample_real;
      logic                  dropped_now;
      logic [FILL_BITS-1:0]  fill_level;
      logic                  priming_now;
      logic [TOTAL_BITS-1:0] underrun_total;
      logic [TOTAL_BITS-1:0] dropped_total;
      logic                  end_marker;
   } pjb_info_type;

   function automatic logic [TOTAL_BITS-1:0] pjb_sat_inc(input logic [TOTAL_BITS-1:0] v);
      logic [TOTAL_BITS-1:0] r;
      r = (v == '1) ? v : v + TOTAL_BITS'(1);
      return r;
   endfunction

endpackage

// ===== hw/rtl/pjb_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module pjb_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pjb_ctrl.sv =====
// ring pointer, fill, priming and totals update; issues sample store accesses
// depends on pjb_pkg
`timescale 1ns / 1ps

module pjb_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_fire,
   input  pjb_pkg::pjb_req_type                 req_data,
   input  logic                                 csr_write_en,
   input  logic [pjb_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [pjb_pkg::CSR_BITS-1:0]         csr_wdata,
   output pjb_pkg::pjb_mem_type                 mem_cmd,
   output pjb_pkg::pjb_info_type                info
);
   import pjb_pkg::*;

   localparam logic [FILL_BITS-1:0] DEPTH_FILL = FILL_BITS'(STORE_DEPTH);

   logic [CSR_BITS-1:0]   cap_ff, cap_in;
   logic [CSR_BITS-1:0]   pre_ff, pre_in;
   logic [IDX_BITS-1:0]   head_ff, head_in;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic                  prime_ff, prime_in;
   logic [TOTAL_BITS-1:0] under_ff, under_in;
   logic [TOTAL_BITS-1:0] drop_ff, drop_in;

   logic [FILL_BITS-1:0]  eff_cap, eff_pre;
   logic [FILL_BITS-1:0]  head_inc;
   logic [IDX_BITS-1:0]   head_adv, head_p, tail;
   logic [FILL_BITS-1:0]  fill_p, tsum;
   logic                  full;
   logic                  real_rd, drop_now;

   always_comb begin
      if (FILL_BITS'(cap_ff) == '0) begin
         eff_cap = FILL_BITS'(1);
      end else if (FILL_BITS'(cap_ff) > DEPTH_FILL) begin
         eff_cap = DEPTH_FILL;
      end else begin
         eff_cap = FILL_BITS'(cap_ff);
      end
      eff_pre  = (FILL_BITS'(pre_ff) < eff_cap) ? FILL_BITS'(pre_ff) : eff_cap;
      head_inc = FILL_BITS'(head_ff) + FILL_BITS'(1);
      head_adv = (head_inc == eff_cap) ? '0 : head_inc[IDX_BITS-1:0];
      full     = (fill_ff >= eff_cap);
      head_p   = full ? head_adv : head_ff;
      fill_p   = full ? fill_ff - FILL_BITS'(1) : fill_ff;
      tsum     = FILL_BITS'(head_p) + fill_p;
      tail     = (tsum >= eff_cap) ? IDX_BITS'(tsum - eff_cap) : tsum[IDX_BITS-1:0];
   end

   always_comb begin
      cap_in   = cap_ff;
      pre_in   = pre_ff;
      head_in  = head_ff;
      fill_in  = fill_ff;
      prime_in = prime_ff;
      under_in = under_ff;
      drop_in  = drop_ff;
      real_rd  = 1'b0;
      drop_now = 1'b0;
      if (csr_write_en) begin
         if (csr_index == CSR_CAPACITY) begin
            cap_in = csr_wdata;
         end else begin
            pre_in = csr_wdata;
         end
         head_in  = '0;
         fill_in  = '0;
         prime_in = 1'b1;
         under_in = '0;
         drop_in  = '0;
      end else if (req_fire) begin
         unique case (req_data.req_type)
            REQ_PUSH: begin
               drop_now = full;
               if (full) begin
                  drop_in = pjb_sat_inc(drop_ff);
               end
               head_in = head_p;
               fill_in = fill_p + FILL_BITS'(1);
               if (prime_ff && (fill_in >= eff_pre)) begin
                  prime_in = 1'b0;
               end
            end
            REQ_PULL: begin
               if (prime_ff) begin
                  under_in = pjb_sat_inc(under_ff);
               end else if (fill_ff == '0) begin
                  under_in = pjb_sat_inc(under_ff);
                  prime_in = 1'b1;
               end else begin
                  real_rd = 1'b1;
                  head_in = head_adv;
                  fill_in = fill_ff - FILL_BITS'(1);
               end
            end
            REQ_CLEAR: begin
               head_in  = '0;
               fill_in  = '0;
               prime_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CSR_BITS'(STORE_DEPTH);
         pre_ff   <= '0;
         head_ff  <= '0;
         fill_ff  <= '0;
         prime_ff <= 1'b1;
         under_ff <= '0;
         drop_ff  <= '0;
      end else begin
         cap_ff   <= cap_in;
         pre_ff   <= pre_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         prime_ff <= prime_in;
         under_ff <= under_in;
         drop_ff  <= drop_in;
      end
   end

   always_comb begin
      mem_cmd.wr_en   = req_fire && !csr_write_en && (req_data.req_type == REQ_PUSH);
      mem_cmd.wr_addr = tail;
      mem_cmd.wr_data = req_data.in_sample;
      mem_cmd.rd_en   = real_rd;
      mem_cmd.rd_addr = head_ff;

      info.sample_real    = real_rd;
      info.dropped_now    = drop_now;
      info.fill_level     = fill_in;
      info.priming_now    = prime_in;
      info.underrun_total = under_in;
      info.dropped_total  = drop_in;
      info.end_marker     = req_data.end_of_call;
   end

endmodule

// ===== hw/rtl/pjb_out.sv =====
// pending stage and output register; merges store read data into the response
// depends on pjb_pkg
`timescale 1ns / 1ps

module pjb_out (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_fire,
   input  pjb_pkg::pjb_info_type                info,
   input  logic [pjb_pkg::SAMPLE_BITS-1:0]      rd_data,
   output logic                                 req_stall,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pjb_pkg::pjb_rsp_type                 rsp_data
);
   import pjb_pkg::*;

   logic         pend_ff, pend_in;
   pjb_info_type pinfo_ff;
   logic         rvalid_ff, rvalid_in;
   pjb_rsp_type  rsp_ff, rsp_in;
   logic         out_load;

   always_comb begin
      out_load  = pend_ff && (!rvalid_ff || !rsp_stall);
      req_stall = pend_ff && !out_load;
      pend_in   = req_fire || (pend_ff && !out_load);
      rvalid_in = out_load || (rvalid_ff && rsp_stall);

      rsp_in.out_sample     = pinfo_ff.sample_real ? rd_data : '0;
      rsp_in.sample_real    = pinfo_ff.sample_real;
      rsp_in.dropped_now    = pinfo_ff.dropped_now;
      rsp_in.fill_level     = pinfo_ff.fill_level;
      rsp_in.priming_now    = pinfo_ff.priming_now;
      rsp_in.underrun_total = pinfo_ff.underrun_total;
      rsp_in.dropped_total  = pinfo_ff.dropped_total;
      rsp_in.end_marker     = pinfo_ff.end_marker;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pinfo_ff <= info;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/pcm_jitter_buffer_top.sv =====
// pcm jitter buffer top level: control, sample store ram and response stage
// depends on pjb_pkg, pjb_ctrl, pjb_ram, pjb_out
`timescale 1ns / 1ps
//
// channel    direction  handshake              payload
// req        in         req_valid / req_stall  pjb_req_type
// rsp        out        rsp_valid / rsp_stall  pjb_rsp_type
// csr        in         csr_write_en           csr_index, csr_wdata
//
// one request per cycle sustained while responses do not stall; a request's
// response passes the pending stage and ram read port, then the output register
// synchronous reset; the sample store is not cleared, no sweep after reset
// a stalled response holds the pending stage, which then stalls requests

module pcm_jitter_buffer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pjb_pkg::pjb_req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pjb_pkg::pjb_rsp_type             rsp_data,
   input  logic                             csr_write_en,
   input  logic [pjb_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [pjb_pkg::CSR_BITS-1:0]     csr_wdata
);
   import pjb_pkg::*;

   logic                   req_fire;
   pjb_mem_type            mem_cmd;
   pjb_info_type           info;
   logic [SAMPLE_BITS-1:0] rd_data;

   assign req_fire = req_valid && !req_stall;

   pjb_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mem_cmd      (mem_cmd),
      .info         (info)
   );

   pjb_ram #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (SAMPLE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_cmd.wr_en),
      .wr_addr (mem_cmd.wr_addr),
      .wr_data (mem_cmd.wr_data),
      .rd_en   (mem_cmd.rd_en),
      .rd_addr (mem_cmd.rd_addr),
      .rd_data (rd_data)
   );

   pjb_out u_out (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .info      (info),
      .rd_data   (rd_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/pjb_checker.sv =====
// port-level checks for the pcm jitter buffer, bound to the top level
// depends on pjb_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pjb_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input pjb_pkg::pjb_rsp_type rsp_data
);
   import pjb_pkg::*;

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `CHK_IMPLY(a_silence_zero, clock, reset, rsp_valid && !rsp_data.sample_real, rsp_data.out_sample == '0)
   `CHK_IMPLY(a_real_not_priming, clock, reset, rsp_valid && rsp_data.sample_real, !rsp_data.priming_now)
   `CHK_IMPLY(a_drop_not_real, clock, reset, rsp_valid && rsp_data.dropped_now, !rsp_data.sample_real && (rsp_data.fill_level != '0))
   `CHK_IMPLY(a_fill_bound, clock, reset, rsp_valid, rsp_data.fill_level <= FILL_BITS'(STORE_DEPTH))

endmodule

bind pcm_jitter_buffer_top pjb_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
